// ===== rtl/core/sic_pkg.sv =====
// Shared constants and types for the segment intersection classifier.
`default_nettype none
package sic_pkg;

	localparam int SIC_COORD_BITS = 16;
	localparam int SIC_FRAC_BITS  = 8;
	localparam int SIC_OUT_BITS   = 24;

	// Kind of meeting between the two segments.
	typedef enum logic [2:0] {
		MK_NONE         = 3'd0,
		MK_DEGEN        = 3'd1,
		MK_CROSS        = 3'd2,
		MK_END_ON_SEG   = 3'd3,
		MK_SHARED_END   = 3'd4,
		MK_OVERLAP      = 3'd5,
		MK_SHARED_COLIN = 3'd6,
		MK_IDENTICAL    = 3'd7
	} meet_kind_t;

endpackage
`default_nettype wire

// ===== rtl/core/segment_intersection_classify.sv =====
// Pipelined classifier of how two 2D line segments meet, with the meeting point.
`default_nettype none
// Each input word carries two segments with signed integer endpoints. The block reports the
// kind of meeting (none, degenerate, proper crossing, endpoint on the other segment, shared
// endpoint, collinear overlap, shared endpoint while collinear, identical) and the meeting
// point in fixed point with FRAC_BITS fraction bits, saturated to 24 bits. All tests are exact
// integer arithmetic. The block is a fully pipelined datapath: one word can enter on every
// clock cycle while the output side does not stall. A word passes through 5 + 1 + 24 + 1
// = 31 registers (five classification stages, the divider entry, 24 divider stages and the
// output register). The restoring divider for the crossing point resolves one quotient bit
// per stage over 24 stages. Every stage holds its word until the next stage is free, so a
// stall on the output side first fills the empty stages and only then lowers in_ready; no
// word is lost or repeated.
module segment_intersection_classify #(
	parameter int COORD_BITS = sic_pkg::SIC_COORD_BITS,
	parameter int FRAC_BITS  = sic_pkg::SIC_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_BITS-1:0]          first_start_x,
	input  logic signed [COORD_BITS-1:0]          first_start_y,
	input  logic signed [COORD_BITS-1:0]          first_end_x,
	input  logic signed [COORD_BITS-1:0]          first_end_y,
	input  logic signed [COORD_BITS-1:0]          second_start_x,
	input  logic signed [COORD_BITS-1:0]          second_start_y,
	input  logic signed [COORD_BITS-1:0]          second_end_x,
	input  logic signed [COORD_BITS-1:0]          second_end_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            meet_kind,
	output logic signed [sic_pkg::SIC_OUT_BITS-1:0] meet_x,
	output logic signed [sic_pkg::SIC_OUT_BITS-1:0] meet_y
);
	import sic_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int OB = SIC_OUT_BITS;
	localparam int DW = C + 1;          // coordinate differences
	localparam int PW = 2 * C + 3;      // cross products of differences
	localparam int KW = 2 * C + 2;      // line constants
	localparam int NW = 3 * C + 4;      // crossing numerators
	localparam int MW = NW + F;         // scaled numerator magnitudes
	localparam int RW = PW + 1;         // divider partial remainder
	localparam int XW = MW + OB + PW;   // overflow compare
	localparam int SW = C + F + OB + 1; // scaled endpoint
	localparam logic signed [SW-1:0] FX_HI = SW'(2 ** (OB - 1) - 1);
	localparam logic signed [SW-1:0] FX_LO = -FX_HI - SW'(1);

	typedef struct packed {
		meet_kind_t             kind;
		logic signed [OB-1:0]   fx;
		logic signed [OB-1:0]   fy;
		logic                   sx;
		logic                   sy;
		logic                   ox;
		logic                   oy;
		logic [RW-1:0]          rx;
		logic [RW-1:0]          ry;
		logic [OB-1:0]          qx;
		logic [OB-1:0]          qy;
		logic [OB-1:0]          lx;
		logic [OB-1:0]          ly;
		logic [PW-1:0]          dmag;
	} div_t;

	function automatic logic pgt(input logic signed [C-1:0] ax, ay, bx, by);
		return (ax > bx) || ((ax == bx) && (ay > by));
	endfunction

	// a*d - b*c
	function automatic logic signed [PW-1:0] xprod(input logic signed [DW-1:0] a, b, c, d);
		logic signed [2*DW-1:0] p;
		logic signed [2*DW-1:0] q;
		p = a * d;
		q = b * c;
		return PW'(p) - PW'(q);
	endfunction

	function automatic logic signed [OB-1:0] fixp(input logic signed [C-1:0] v);
		logic signed [SW-1:0] s;
		s = SW'(v) <<< F;
		if (s > FX_HI) begin
			return OB'(FX_HI);
		end else if (s < FX_LO) begin
			return OB'(FX_LO);
		end
		return OB'(s);
	endfunction

	function automatic logic signed [OB-1:0] sat(input logic neg, ovf, input logic [OB-1:0] q);
		logic [OB-1:0] lim;
		lim = {1'b1, {(OB-1){1'b0}}};
		if (neg) begin
			return (ovf || q > lim) ? lim : (~q + OB'(1));
		end
		return (ovf || q[OB-1]) ? ~lim : q;
	endfunction

	// Stage enables: a stage may load when it is empty or its word moves on.
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;
	logic [OB:0] en_dv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic [OB:0] v_dv;
	div_t dv_sn [OB+1];

	assign en_out = !out_valid_q || out_ready;
	assign en_dv[OB] = !v_dv[OB] || en_out;
	for (genvar j = 0; j < OB; j++) begin : g_en
		assign en_dv[j] = !v_dv[j] || en_dv[j+1];
	end
	assign en_s5 = !v_s5 || en_dv[0];
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_dv <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_dv[0]) v_dv[0] <= v_s5;
			for (int j = 1; j <= OB; j++) begin
				if (en_dv[j]) v_dv[j] <= v_dv[j-1];
			end
			if (en_out) out_valid_q <= v_dv[OB];
		end
	end

	// Stage 1: each segment is turned so that its start is the smaller point.
	logic sw1, sw2;
	logic signed [C-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;
	logic deg_s1;

	assign sw1 = pgt(first_start_x, first_start_y, first_end_x, first_end_y);
	assign sw2 = pgt(second_start_x, second_start_y, second_end_x, second_end_y);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ax_s1 <= sw1 ? first_end_x : first_start_x;
			ay_s1 <= sw1 ? first_end_y : first_start_y;
			bx_s1 <= sw1 ? first_start_x : first_end_x;
			by_s1 <= sw1 ? first_start_y : first_end_y;
			cx_s1 <= sw2 ? second_end_x : second_start_x;
			cy_s1 <= sw2 ? second_end_y : second_start_y;
			dx_s1 <= sw2 ? second_start_x : second_end_x;
			dy_s1 <= sw2 ? second_start_y : second_end_y;
			deg_s1 <= (first_start_x == first_end_x && first_start_y == first_end_y) ||
				(second_start_x == second_end_x && second_start_y == second_end_y);
		end
	end

	// Stage 2: shared endpoint tests, then the segment that starts first becomes the first.
	logic sh_ac, sh_bd, sh_ad, sh_bc, sw3;
	logic signed [C-1:0] a2x, a2y, b2x, b2y, c2x, c2y, d2x, d2y;
	logic signed [C-1:0] ax_s2, ay_s2, bx_s2, by_s2, cx_s2, cy_s2, dx_s2, dy_s2;
	logic signed [C-1:0] shx_s2, shy_s2;
	logic signed [DW-1:0] ux_s2, uy_s2, vx_s2, vy_s2, ex_s2, ey_s2, fx_s2, fy_s2, gx_s2, gy_s2;
	logic deg_s2, ident_s2, sh_any_s2, sh_par_s2;

	assign sh_ac = (ax_s1 == cx_s1) && (ay_s1 == cy_s1);
	assign sh_bd = (bx_s1 == dx_s1) && (by_s1 == dy_s1);
	assign sh_ad = (ax_s1 == dx_s1) && (ay_s1 == dy_s1);
	assign sh_bc = (bx_s1 == cx_s1) && (by_s1 == cy_s1);
	assign sw3 = pgt(ax_s1, ay_s1, cx_s1, cy_s1);
	assign a2x = sw3 ? cx_s1 : ax_s1;
	assign a2y = sw3 ? cy_s1 : ay_s1;
	assign b2x = sw3 ? dx_s1 : bx_s1;
	assign b2y = sw3 ? dy_s1 : by_s1;
	assign c2x = sw3 ? ax_s1 : cx_s1;
	assign c2y = sw3 ? ay_s1 : cy_s1;
	assign d2x = sw3 ? bx_s1 : dx_s1;
	assign d2y = sw3 ? by_s1 : dy_s1;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ax_s2 <= a2x;
			ay_s2 <= a2y;
			bx_s2 <= b2x;
			by_s2 <= b2y;
			cx_s2 <= c2x;
			cy_s2 <= c2y;
			dx_s2 <= d2x;
			dy_s2 <= d2y;
			ux_s2 <= DW'(b2x) - DW'(a2x);
			uy_s2 <= DW'(b2y) - DW'(a2y);
			vx_s2 <= DW'(d2x) - DW'(c2x);
			vy_s2 <= DW'(d2y) - DW'(c2y);
			ex_s2 <= DW'(c2x) - DW'(a2x);
			ey_s2 <= DW'(c2y) - DW'(a2y);
			fx_s2 <= DW'(b2x) - DW'(c2x);
			fy_s2 <= DW'(b2y) - DW'(c2y);
			gx_s2 <= DW'(d2x) - DW'(a2x);
			gy_s2 <= DW'(d2y) - DW'(a2y);
			deg_s2 <= deg_s1;
			ident_s2 <= sh_ac && sh_bd;
			sh_any_s2 <= sh_ac || sh_bd || sh_ad || sh_bc;
			sh_par_s2 <= sh_ac || sh_bd;
			shx_s2 <= (sh_ac || (!sh_bd && sh_ad)) ? ax_s1 : bx_s1;
			shy_s2 <= (sh_ac || (!sh_bd && sh_ad)) ? ay_s1 : by_s1;
		end
	end

	// Stage 3: all cross products and the ordering and bounding box tests.
	logic signed [PW-1:0] cr3, s1v, s2v, t1v, t2v, ka3, kb3;
	logic signed [C-1:0] ymax1, ymin1, ymax2, ymin2;
	logic signed [PW-1:0] cr_s3;
	logic signed [KW-1:0] ka_s3, kb_s3;
	logic signed [DW-1:0] ux_s3, uy_s3, vx_s3, vy_s3;
	logic signed [C-1:0] ax_s3, ay_s3, bx_s3, by_s3, cx_s3, cy_s3, dx_s3, dy_s3;
	logic signed [C-1:0] shx_s3, shy_s3;
	logic deg_s3, ident_s3, sh_any_s3, sh_par_s3, box_out_s3;
	logic s1z_s3, s1n_s3, s2z_s3, s2n_s3, t1z_s3, t1n_s3, t2z_s3, t2n_s3;
	logic p_da_s3, p_ac_s3, p_bc_s3, p_db_s3, p_ca_s3, p_bd_s3;

	assign cr3 = xprod(ux_s2, uy_s2, vx_s2, vy_s2);
	assign s1v = xprod(ey_s2, ex_s2, vy_s2, vx_s2);
	assign s2v = xprod(fx_s2, fy_s2, vx_s2, vy_s2);
	assign t1v = xprod(ex_s2, ey_s2, ux_s2, uy_s2);
	assign t2v = xprod(gx_s2, gy_s2, ux_s2, uy_s2);
	assign ka3 = xprod(DW'(ax_s2), DW'(ay_s2), ux_s2, uy_s2);
	assign kb3 = xprod(DW'(cx_s2), DW'(cy_s2), vx_s2, vy_s2);
	assign ymax1 = (ay_s2 > by_s2) ? ay_s2 : by_s2;
	assign ymin1 = (ay_s2 > by_s2) ? by_s2 : ay_s2;
	assign ymax2 = (cy_s2 > dy_s2) ? cy_s2 : dy_s2;
	assign ymin2 = (cy_s2 > dy_s2) ? dy_s2 : cy_s2;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cr_s3 <= cr3;
			ka_s3 <= KW'(ka3);
			kb_s3 <= KW'(kb3);
			s1z_s3 <= (s1v == '0);
			s1n_s3 <= s1v[PW-1];
			s2z_s3 <= (s2v == '0);
			s2n_s3 <= s2v[PW-1];
			t1z_s3 <= (t1v == '0);
			t1n_s3 <= t1v[PW-1];
			t2z_s3 <= (t2v == '0);
			t2n_s3 <= t2v[PW-1];
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			shx_s3 <= shx_s2;
			shy_s3 <= shy_s2;
			deg_s3 <= deg_s2;
			ident_s3 <= ident_s2;
			sh_any_s3 <= sh_any_s2;
			sh_par_s3 <= sh_par_s2;
			box_out_s3 <= (ax_s2 > dx_s2) || (bx_s2 < cx_s2) || (ymax1 < ymin2) ||
				(ymin1 > ymax2);
			p_da_s3 <= pgt(dx_s2, dy_s2, ax_s2, ay_s2);
			p_ac_s3 <= pgt(ax_s2, ay_s2, cx_s2, cy_s2);
			p_bc_s3 <= pgt(bx_s2, by_s2, cx_s2, cy_s2);
			p_db_s3 <= pgt(dx_s2, dy_s2, bx_s2, by_s2);
			p_ca_s3 <= pgt(cx_s2, cy_s2, ax_s2, ay_s2);
			p_bd_s3 <= pgt(bx_s2, by_s2, dx_s2, dy_s2);
		end
	end

	// Stage 4: the class is settled; crossing numerator products start.
	meet_kind_t k4;
	logic signed [C-1:0] px4, py4;
	logic cr0;
	logic signed [KW+DW-1:0] m_kx, m_ax, m_ky, m_ay;
	meet_kind_t kind_s4;
	logic signed [OB-1:0] fx_s4, fy_s4;
	logic signed [KW+DW-1:0] kx_s4, axp_s4, ky_s4, ayp_s4;
	logic signed [PW-1:0] cr_s4;

	assign cr0 = (cr_s3 == '0);

	always_comb begin
		k4 = MK_NONE;
		px4 = shx_s3;
		py4 = shy_s3;
		if (deg_s3) begin
			k4 = MK_DEGEN;
		end else if (ident_s3) begin
			k4 = MK_IDENTICAL;
		end else if (sh_any_s3) begin
			k4 = (sh_par_s3 && cr0) ? MK_SHARED_COLIN : MK_SHARED_END;
		end else if (cr0) begin
			px4 = cx_s3;
			py4 = cy_s3;
			k4 = (t1z_s3 && p_bc_s3) ? MK_OVERLAP : MK_NONE;
		end else if (box_out_s3) begin
			k4 = MK_NONE;
		end else if (s1z_s3 && p_da_s3 && p_ac_s3) begin
			k4 = MK_END_ON_SEG;
			px4 = ax_s3;
			py4 = ay_s3;
		end else if (s2z_s3 && p_db_s3 && p_bc_s3) begin
			k4 = MK_END_ON_SEG;
			px4 = bx_s3;
			py4 = by_s3;
		end else if (t1z_s3 && p_bc_s3 && p_ca_s3) begin
			k4 = MK_END_ON_SEG;
			px4 = cx_s3;
			py4 = cy_s3;
		end else if (t2z_s3 && p_bd_s3 && p_da_s3) begin
			k4 = MK_END_ON_SEG;
			px4 = dx_s3;
			py4 = dy_s3;
		end else if ((!s1z_s3 && !s2z_s3 && (s1n_s3 == s2n_s3)) ||
			(!t1z_s3 && !t2z_s3 && (t1n_s3 == t2n_s3))) begin
			k4 = MK_NONE;
		end else begin
			k4 = MK_CROSS;
		end
	end

	assign m_kx = kb_s3 * ux_s3;
	assign m_ax = ka_s3 * vx_s3;
	assign m_ky = kb_s3 * uy_s3;
	assign m_ay = ka_s3 * vy_s3;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			kind_s4 <= k4;
			if (k4 inside {MK_END_ON_SEG, MK_SHARED_END, MK_OVERLAP, MK_SHARED_COLIN}) begin
				fx_s4 <= fixp(px4);
				fy_s4 <= fixp(py4);
			end else begin
				fx_s4 <= '0;
				fy_s4 <= '0;
			end
			kx_s4 <= m_kx;
			axp_s4 <= m_ax;
			ky_s4 <= m_ky;
			ayp_s4 <= m_ay;
			cr_s4 <= cr_s3;
		end
	end

	// Stage 5: numerators and divisor go to sign and magnitude; numerators are scaled.
	logic signed [NW-1:0] nx5, ny5;
	logic [NW-1:0] mx5, my5;
	meet_kind_t kind_s5;
	logic signed [OB-1:0] fx_s5, fy_s5;
	logic [MW-1:0] nmx_s5, nmy_s5;
	logic sx_s5, sy_s5;
	logic [PW-1:0] dmag_s5;

	assign nx5 = NW'(kx_s4) - NW'(axp_s4);
	assign ny5 = NW'(ky_s4) - NW'(ayp_s4);
	assign mx5 = nx5[NW-1] ? (~nx5 + NW'(1)) : nx5;
	assign my5 = ny5[NW-1] ? (~ny5 + NW'(1)) : ny5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			kind_s5 <= kind_s4;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			nmx_s5 <= MW'(mx5) << F;
			nmy_s5 <= MW'(my5) << F;
			sx_s5 <= nx5[NW-1] ^ cr_s4[PW-1];
			sy_s5 <= ny5[NW-1] ^ cr_s4[PW-1];
			dmag_s5 <= cr_s4[PW-1] ? (~cr_s4 + PW'(1)) : cr_s4;
		end
	end

	// Divider entry: overflow test and the starting remainder from the high part.
	always_ff @(posedge clk) begin
		if (en_dv[0]) begin
			dv_sn[0].kind <= kind_s5;
			dv_sn[0].fx <= fx_s5;
			dv_sn[0].fy <= fy_s5;
			dv_sn[0].sx <= sx_s5;
			dv_sn[0].sy <= sy_s5;
			dv_sn[0].ox <= XW'(nmx_s5) >= (XW'(dmag_s5) << OB);
			dv_sn[0].oy <= XW'(nmy_s5) >= (XW'(dmag_s5) << OB);
			dv_sn[0].rx <= RW'(nmx_s5 >> OB);
			dv_sn[0].ry <= RW'(nmy_s5 >> OB);
			dv_sn[0].qx <= '0;
			dv_sn[0].qy <= '0;
			dv_sn[0].lx <= nmx_s5[OB-1:0];
			dv_sn[0].ly <= nmy_s5[OB-1:0];
			dv_sn[0].dmag <= dmag_s5;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant bit first.
	for (genvar j = 1; j <= OB; j++) begin : g_div
		logic [RW-1:0] trx, try_;
		logic gex, gey;
		div_t nxt;

		always_comb begin
			nxt = dv_sn[j-1];
			trx = {dv_sn[j-1].rx[RW-2:0], dv_sn[j-1].lx[OB-j]};
			try_ = {dv_sn[j-1].ry[RW-2:0], dv_sn[j-1].ly[OB-j]};
			gex = trx >= RW'(dv_sn[j-1].dmag);
			gey = try_ >= RW'(dv_sn[j-1].dmag);
			nxt.rx = gex ? (trx - RW'(dv_sn[j-1].dmag)) : trx;
			nxt.ry = gey ? (try_ - RW'(dv_sn[j-1].dmag)) : try_;
			nxt.qx[OB-j] = gex;
			nxt.qy[OB-j] = gey;
		end

		always_ff @(posedge clk) begin
			if (en_dv[j]) begin
				dv_sn[j] <= nxt;
			end
		end
	end

	// Output register: crossing points are saturated and signed, others pass through.
	meet_kind_t kind_q;
	logic signed [OB-1:0] mx_q, my_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			kind_q <= dv_sn[OB].kind;
			if (dv_sn[OB].kind == MK_CROSS) begin
				mx_q <= sat(dv_sn[OB].sx, dv_sn[OB].ox, dv_sn[OB].qx);
				my_q <= sat(dv_sn[OB].sy, dv_sn[OB].oy, dv_sn[OB].qy);
			end else begin
				mx_q <= dv_sn[OB].fx;
				my_q <= dv_sn[OB].fy;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign meet_kind = kind_q;
	assign meet_x = mx_q;
	assign meet_y = my_q;

	// With the output register empty every stage can advance, so input must be open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low while output register is empty");

	a_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (meet_kind == MK_NONE || meet_kind == MK_DEGEN ||
		meet_kind == MK_IDENTICAL)) |-> (meet_x == '0 && meet_y == '0))
		else $error("meeting point nonzero for a kind without a point");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv[OB] && dv_sn[OB].kind == MK_CROSS) |-> (dv_sn[OB].dmag != '0))
		else $error("crossing reached divider end with zero divisor");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv[OB] && dv_sn[OB].kind == MK_CROSS && !dv_sn[OB].ox) |->
		(dv_sn[OB].rx < RW'(dv_sn[OB].dmag)))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
